FILE: rtl/complete_tree_store_macros.svh
// ---------------------------------------------------------------------------
// complete_tree_store assertion macros
// shared property forms used by the tree store checks
// ---------------------------------------------------------------------------
`ifndef COMPLETE_TREE_STORE_MACROS_SVH
`define COMPLETE_TREE_STORE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CTS_ASSERT_HOLD(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define CTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cts_pkg.sv
// ---------------------------------------------------------------------------
// cts_pkg
// types and constants shared by the complete tree store modules
// ---------------------------------------------------------------------------
package cts_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int ST_W     = 3;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_INSERT    = 3'd0,
		OP_DELETE    = 3'd1,
		OP_INORDER   = 3'd2,
		OP_PREORDER  = 3'd3,
		OP_POSTORDER = 3'd4
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_ITEM      = 3'd4,
		ST_EMPTY     = 3'd5
	} st_t;

	// direction from which the walker arrived at the current node
	typedef enum logic [1:0] {
		FROM_PARENT,
		FROM_LEFT,
		FROM_RIGHT
	} from_t;

	// main sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_INS,
		S_SCAN,
		S_DLAST,
		S_DWRITE,
		S_RESULT,
		S_WALK,
		S_PUSH,
		S_FLUSH
	} state_t;

	// walker report to the sequencer
	typedef struct packed {
		logic              emit;
		logic              done;
		logic [ADDR_W-1:0] addr;
	} walk_t;

endpackage

FILE: rtl/cts_walk.sv
// ---------------------------------------------------------------------------
// cts_walk
// stackless depth-first walker over a level-order complete binary tree
// ---------------------------------------------------------------------------
module cts_walk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       step,
	input  cts_pkg::op_t               mode,
	input  logic [cts_pkg::CNT_W-1:0]  count,
	output cts_pkg::walk_t             info
);
	import cts_pkg::*;

	logic [CNT_W-1:0] n_q, n_d;
	from_t            from_q, from_d;
	op_t              mode_q;
	logic [CNT_W:0]   left_idx, right_idx, cnt_ext;
	logic             has_left, has_right;

	// child indices, one-based so children sit at 2n and 2n+1
	assign left_idx  = {n_q, 1'b0};
	assign right_idx = {n_q, 1'b1};
	assign cnt_ext   = {1'b0, count};
	assign has_left  = (left_idx <= cnt_ext);
	assign has_right = (right_idx <= cnt_ext);

	// one visit per step
	always_comb begin
		n_d       = n_q;
		from_d    = from_q;
		info.emit = 1'b0;
		info.done = 1'b0;
		info.addr = ADDR_W'(n_q - CNT_W'(1));
		unique case (from_q)
			FROM_PARENT: begin
				info.emit = (mode_q == OP_PREORDER);
				if (has_left) begin
					n_d = left_idx[CNT_W-1:0];
				end else begin
					from_d = FROM_LEFT;
				end
			end
			FROM_LEFT: begin
				info.emit = (mode_q == OP_INORDER);
				if (has_right) begin
					n_d    = right_idx[CNT_W-1:0];
					from_d = FROM_PARENT;
				end else begin
					from_d = FROM_RIGHT;
				end
			end
			FROM_RIGHT: begin
				info.emit = (mode_q == OP_POSTORDER);
				if (n_q == CNT_W'(1)) begin
					info.done = 1'b1;
				end else begin
					n_d    = n_q >> 1;
					from_d = n_q[0] ? FROM_RIGHT : FROM_LEFT;
				end
			end
			default: begin
				from_d = FROM_PARENT;
			end
		endcase
	end

	// walker position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= CNT_W'(1);
			from_q <= FROM_PARENT;
			mode_q <= OP_INORDER;
		end else if (start) begin
			n_q    <= CNT_W'(1);
			from_q <= FROM_PARENT;
			mode_q <= mode;
		end else if (step) begin
			n_q    <= n_d;
			from_q <= from_d;
		end
	end

endmodule

FILE: rtl/complete_tree_store.sv
// ---------------------------------------------------------------------------
// complete_tree_store
// complete binary tree of signed 32-bit values held in level-order form
// ---------------------------------------------------------------------------
// One word in (op, value) on a valid/ready channel, one or more words out
// (status, item_value, last_of_run) on a valid/ready channel. The block takes
// one word at a time: in_ready is high only while the sequencer is idle.
// Insert: the sequencer passes through S_INS and then S_RESULT, which loads
// the result into the output register. Delete: the node store is scanned
// one entry a cycle through its single registered read port; S_DLAST then
// reads the final node and S_DWRITE moves it into a matched slot.
// Traversals: the walker visits each node three times, one visit a cycle in
// S_WALK; each emitted value passes S_PUSH, which can wait on a held output
// register. An empty tree gives one word with status empty.
// The last word of every run carries last_of_run. Results leave through an
// output register, so the next word is accepted while a result waits.
// A stalled receiver holds the output register and the sequencer waits on it.
// Reset clears the node count and all control state; stored values are
// undefined until written and no clearing pass runs.
// ---------------------------------------------------------------------------
`include "complete_tree_store_macros.svh"

module complete_tree_store (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [cts_pkg::OP_W-1:0]           op,
	input  logic signed [cts_pkg::DATA_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cts_pkg::ST_W-1:0]           status,
	output logic signed [cts_pkg::DATA_W-1:0]  item_value,
	output logic                               last_of_run
);
	import cts_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, idx_q;
	logic [DATA_W-1:0] value_q, rdata_q, pend_q, item_q;
	logic [DATA_W-1:0] node_mem_q [CAPACITY];
	logic              cmp_vld_s1;
	logic [ADDR_W-1:0] cmp_idx_s1, target_q, emit_addr_q;
	logic              found_q, done_q, pend_vld_q;
	st_t               res_status_q, res_d, status_q;
	logic              out_vld_q, last_q;

	logic              out_free, out_load, out_last_d;
	logic [DATA_W-1:0] out_item_d;
	st_t               out_st_d;
	logic              res_set, count_inc, count_dec, scan_issue;
	logic              pend_load, pend_clear, emit_save;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, rd_addr;
	logic [DATA_W-1:0] mem_wdata;
	logic              walk_start, walk_step;
	walk_t             walk;

	assign out_free = !out_vld_q || out_ready;

	// traversal walker
	cts_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (walk_start),
		.step   (walk_step),
		.mode   (op_t'(op)),
		.count  (count_q),
		.info   (walk)
	);

	// sequencer next state and controls
	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_load   = 1'b0;
		out_st_d   = ST_ITEM;
		out_item_d = pend_q;
		out_last_d = 1'b0;
		res_set    = 1'b0;
		res_d      = ST_INSERTED;
		count_inc  = 1'b0;
		count_dec  = 1'b0;
		scan_issue = 1'b0;
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		emit_save  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = count_q[ADDR_W-1:0];
		mem_wdata  = value_q;
		rd_addr    = walk.addr;
		walk_start = 1'b0;
		walk_step  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op_t'(op)) inside
						OP_INSERT: state_d = S_INS;
						OP_DELETE: state_d = S_SCAN;
						OP_INORDER, OP_PREORDER, OP_POSTORDER: begin
							walk_start = 1'b1;
							if (count_q == '0) begin
								res_set = 1'b1;
								res_d   = ST_EMPTY;
								state_d = S_RESULT;
							end else begin
								state_d = S_WALK;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS: begin
				res_set = 1'b1;
				if (count_q < CNT_W'(CAPACITY)) begin
					mem_we    = 1'b1;
					count_inc = 1'b1;
					res_d     = ST_INSERTED;
				end else begin
					res_d = ST_FULL;
				end
				state_d = S_RESULT;
			end
			S_SCAN: begin
				rd_addr = idx_q[ADDR_W-1:0];
				if (idx_q == count_q) begin
					state_d = S_DLAST;
				end else begin
					scan_issue = 1'b1;
				end
			end
			S_DLAST: begin
				rd_addr = count_q[ADDR_W-1:0] - ADDR_W'(1);
				state_d = S_DWRITE;
			end
			S_DWRITE: begin
				res_set = 1'b1;
				if (found_q) begin
					mem_we    = 1'b1;
					mem_waddr = target_q;
					mem_wdata = rdata_q;
					count_dec = 1'b1;
					res_d     = ST_DELETED;
				end else begin
					res_d = ST_NOT_FOUND;
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_st_d   = res_status_q;
					out_item_d = '0;
					out_last_d = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_WALK: begin
				walk_step = 1'b1;
				if (walk.emit) begin
					emit_save = 1'b1;
					state_d   = S_PUSH;
				end else if (walk.done) begin
					state_d = S_FLUSH;
				end
			end
			S_PUSH: begin
				rd_addr = emit_addr_q;
				if (!pend_vld_q) begin
					pend_load = 1'b1;
					state_d   = done_q ? S_FLUSH : S_WALK;
				end else if (out_free) begin
					out_load  = 1'b1;
					pend_load = 1'b1;
					state_d   = done_q ? S_FLUSH : S_WALK;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_last_d = 1'b1;
					pend_clear = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			done_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= scan_issue;
			if (count_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			// scan index and match tracking for delete
			if (in_valid && in_ready) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (scan_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmp_vld_s1 && (rdata_q == value_q)) begin
					found_q <= 1'b1;
				end
			end
			if (emit_save) begin
				done_q <= walk.done;
			end
			if (pend_load) begin
				pend_vld_q <= 1'b1;
			end else if (pend_clear) begin
				pend_vld_q <= 1'b0;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q[ADDR_W-1:0];
		if (in_valid && in_ready) begin
			value_q <= value;
		end
		if (cmp_vld_s1 && (rdata_q == value_q)) begin
			target_q <= cmp_idx_s1;
		end
		if (res_set) begin
			res_status_q <= res_d;
		end
		if (emit_save) begin
			emit_addr_q <= walk.addr;
		end
		if (pend_load) begin
			pend_q <= rdata_q;
		end
		if (out_load) begin
			status_q <= out_st_d;
			item_q   <= out_item_d;
			last_q   <= out_last_d;
		end
	end

	// node store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= node_mem_q[rd_addr];
	end

	assign out_valid   = out_vld_q;
	assign status      = status_q;
	assign item_value  = item_q;
	assign last_of_run = last_q;

	// checks
	`CTS_ASSERT_HOLD(a_count_range, count_q <= CNT_W'(CAPACITY), "node count above capacity")
	`CTS_ASSERT_NEXT(a_insert_grows,
		(state_q == S_INS) && (count_q < CNT_W'(CAPACITY)),
		count_q == $past(count_q) + CNT_W'(1), "insert did not grow the tree")
	`CTS_ASSERT_NEXT(a_miss_keeps, (state_q == S_DWRITE) && !found_q,
		count_q == $past(count_q), "unmatched delete changed the count")
	`CTS_ASSERT_IMPL(a_open_run_item, out_vld_q && !last_q, status_q == ST_ITEM,
		"open run word is not a traversal item")

endmodule

FILE: bench/tb_complete_tree_store.sv
// ---------------------------------------------------------------------------
// tb_complete_tree_store
// self-checking bench for the level-order complete tree store
// ---------------------------------------------------------------------------
// Words go in over a valid/ready channel and every accepted word is run
// through a local copy of the tree at the moment of acceptance. The result
// words that copy gives are queued and compared field by field with what
// leaves the block. A directed table opens the run: empty-tree traversals,
// the only node deleted, duplicates, the final node deleted, misses, extreme
// values and the spare op codes. A fill to capacity follows under a long
// receiver hold-off, with traversals of the full tree. Random traffic with
// idle bursts on both sides closes the run.
// ---------------------------------------------------------------------------
module tb_complete_tree_store;
	import cts_pkg::*;

	// spare op codes that the block ignores
	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	localparam int DIR_ROWS    = 24;
	localparam int RAND_WORDS  = 150;
	localparam int CALM_TAIL   = 60;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 300;

	typedef struct packed {
		logic [ST_W-1:0]   st;
		logic [DATA_W-1:0] data;
		logic              last;
	} word_t;

	typedef struct packed {
		logic [OP_W-1:0]   code;
		logic [DATA_W-1:0] data;
		logic              typed;
		logic [ST_W-1:0]   want_st;
		logic [DATA_W-1:0] want_data;
		logic              want_last;
	} row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic [ST_W-1:0]          status;
	logic signed [DATA_W-1:0] item_value;
	logic                     last_of_run;

	// local copy of the tree and the words it says are due
	logic [DATA_W-1:0] tree_vals [CAPACITY];
	int                tree_count;
	word_t             run_words[$];
	word_t             pending_words[$];

	int  mismatch_count = 0;
	int  words_checked  = 0;
	int  items_sent     = 0;
	int  spare_sent     = 0;
	int  seen_status [8];
	int  long_hold      = 0;
	bit  calm           = 1'b0;
	word_t want;
	row_t  dir_rows [DIR_ROWS];

	complete_tree_store DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.item_value  (item_value),
		.last_of_run (last_of_run)
	);

	// clock
	always #2 clk = ~clk;

	// run limit
	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch on %s: got %h, expected %h", field, got, exp_val);
	endtask

	function automatic void note_word(input logic [ST_W-1:0] st, input logic [DATA_W-1:0] data,
			input logic last);
		word_t w;
		w.st   = st;
		w.data = data;
		w.last = last;
		run_words.push_back(w);
	endfunction

	// tree update for one accepted word; result words land in run_words
	function automatic void tree_step(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data);
		int    hit;
		int    sp;
		int    node;
		int    stk_node [8];
		int    stk_visit [8];
		word_t w;
		run_words.delete();
		case (code)
		OP_INSERT: begin
			if (tree_count >= CAPACITY) begin
				note_word(ST_FULL, '0, 1'b1);
			end else begin
				tree_vals[tree_count] = data;
				tree_count++;
				note_word(ST_INSERTED, '0, 1'b1);
			end
		end
		OP_DELETE: begin
			// last match in level order wins
			hit = -1;
			for (int i = 0; i < tree_count; i++)
				if (tree_vals[i] == data)
					hit = i;
			if (hit < 0) begin
				note_word(ST_NOT_FOUND, '0, 1'b1);
			end else begin
				tree_vals[hit] = tree_vals[tree_count - 1];
				tree_count--;
				note_word(ST_DELETED, '0, 1'b1);
			end
		end
		OP_INORDER, OP_PREORDER, OP_POSTORDER: begin
			if (tree_count == 0) begin
				note_word(ST_EMPTY, '0, 1'b1);
			end else begin
				// explicit stack walk, children of i at 2i+1 and 2i+2
				sp = 0;
				stk_node[0] = 0;
				stk_visit[0] = 0;
				while (sp >= 0) begin
					node = stk_node[sp];
					if (node >= tree_count) begin
						sp--;
					end else if (stk_visit[sp] == 0) begin
						if (code == OP_PREORDER)
							note_word(ST_ITEM, tree_vals[node], 1'b0);
						stk_visit[sp] = 1;
						sp++;
						stk_node[sp] = 2 * node + 1;
						stk_visit[sp] = 0;
					end else if (stk_visit[sp] == 1) begin
						if (code == OP_INORDER)
							note_word(ST_ITEM, tree_vals[node], 1'b0);
						stk_visit[sp] = 2;
						sp++;
						stk_node[sp] = 2 * node + 2;
						stk_visit[sp] = 0;
					end else begin
						if (code == OP_POSTORDER)
							note_word(ST_ITEM, tree_vals[node], 1'b0);
						sp--;
					end
				end
				w = run_words.pop_back();
				w.last = 1'b1;
				run_words.push_back(w);
			end
		end
		default: ;
		endcase
	endfunction

	// offer one word from a falling edge, optionally after an idle burst
	task automatic send_word(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] data,
			input logic typed, input word_t fixed_word);
		int gap;
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		value    <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tree_step(code, data);
		if (typed) begin
			pending_words.push_back(fixed_word);
		end else begin
			foreach (run_words[k])
				pending_words.push_back(run_words[k]);
		end
		if (code == OP_RSVD_5 || code == OP_RSVD_6 || code == OP_RSVD_7)
			spare_sent++;
		else
			items_sent++;
		@(negedge clk);
	endtask

	// sender pause until every due word has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_words.size() != 0);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		if (pick < 3)
			return $urandom_range(0, 15);
		return $urandom;
	endfunction

	function automatic logic [DATA_W-1:0] stored_value();
		return tree_vals[$urandom_range(0, tree_count - 1)];
	endfunction

	function automatic logic [OP_W-1:0] pick_walk();
		case ($urandom_range(0, 2))
		0: return OP_INORDER;
		1: return OP_PREORDER;
		default: return OP_POSTORDER;
		endcase
	endfunction

	// receiver: random stall bursts, plus a long hold-off on request
	initial begin : rx_side
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				n = long_hold;
				long_hold = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
			end else begin
				n = 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_checked++;
			seen_status[status]++;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word status", {29'd0, status}, '0);
			end else begin
				want = pending_words.pop_front();
				if (status !== want.st)
					report_mismatch("status", {29'd0, status}, {29'd0, want.st});
				if (item_value !== want.data)
					report_mismatch("item_value", item_value, want.data);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", {31'd0, last_of_run}, {31'd0, want.last});
			end
		end
	end

	// stimulus
	initial begin
		int done;
		int pick;
		logic [OP_W-1:0]   code;
		logic [DATA_W-1:0] data;
		word_t fixed_word;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		op        = OP_INSERT;
		value     = '0;
		tree_count = 0;
		foreach (seen_status[k])
			seen_status[k] = 0;

		// directed table: typed rows carry their obvious result, the rest use the tree copy
		dir_rows = '{
			'{OP_INORDER,   32'h0000_0000, 1'b1, ST_EMPTY,     32'h0, 1'b1},
			'{OP_PREORDER,  32'hFFFF_FFFF, 1'b1, ST_EMPTY,     32'h0, 1'b1},
			'{OP_POSTORDER, 32'h0000_0000, 1'b1, ST_EMPTY,     32'h0, 1'b1},
			'{OP_DELETE,    32'h0000_0005, 1'b1, ST_NOT_FOUND, 32'h0, 1'b1},
			'{OP_INSERT,    32'h8000_0000, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_DELETE,    32'h8000_0000, 1'b1, ST_DELETED,   32'h0, 1'b1},
			'{OP_INORDER,   32'h0000_0000, 1'b1, ST_EMPTY,     32'h0, 1'b1},
			'{OP_INSERT,    32'h7FFF_FFFF, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INSERT,    32'h8000_0000, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INSERT,    32'h0000_0000, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INSERT,    32'hFFFF_FFFF, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INSERT,    32'h7FFF_FFFF, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INSERT,    32'h5555_5555, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INSERT,    32'hAAAA_AAAA, 1'b1, ST_INSERTED,  32'h0, 1'b1},
			'{OP_INORDER,   32'h0000_0000, 1'b0, '0,           '0,    '0},
			'{OP_PREORDER,  32'h0000_0000, 1'b0, '0,           '0,    '0},
			'{OP_POSTORDER, 32'h0000_0000, 1'b0, '0,           '0,    '0},
			// duplicate: the later copy goes, the final node moves into its slot
			'{OP_DELETE,    32'h7FFF_FFFF, 1'b1, ST_DELETED,   32'h0, 1'b1},
			// the final node itself
			'{OP_DELETE,    32'h5555_5555, 1'b1, ST_DELETED,   32'h0, 1'b1},
			'{OP_DELETE,    32'h1234_5678, 1'b1, ST_NOT_FOUND, 32'h0, 1'b1},
			'{OP_RSVD_5,    32'h0000_0000, 1'b0, '0,           '0,    '0},
			'{OP_RSVD_6,    32'h7FFF_FFFF, 1'b0, '0,           '0,    '0},
			'{OP_RSVD_7,    32'hFFFF_FFFF, 1'b0, '0,           '0,    '0},
			'{OP_PREORDER,  32'h0000_0000, 1'b0, '0,           '0,    '0}
		};

		// reset once
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		foreach (dir_rows[r]) begin
			fixed_word.st   = dir_rows[r].want_st;
			fixed_word.data = dir_rows[r].want_data;
			fixed_word.last = dir_rows[r].want_last;
			send_word(dir_rows[r].code, dir_rows[r].data, dir_rows[r].typed, fixed_word);
		end
		drain_results();

		// fill to capacity behind a long receiver hold-off, then walk the full tree
		long_hold = HOLD_CYCLES;
		while (tree_count < CAPACITY)
			send_word(OP_INSERT, pick_value(), 1'b0, '0);
		send_word(OP_INSERT, pick_value(), 1'b0, '0);
		send_word(OP_INORDER, '0, 1'b0, '0);
		send_word(OP_PREORDER, '0, 1'b0, '0);
		send_word(OP_POSTORDER, '0, 1'b0, '0);
		while (tree_count > 8) begin
			if ($urandom_range(0, 7) == 0)
				send_word(OP_DELETE, $urandom, 1'b0, '0);
			else
				send_word(OP_DELETE, stored_value(), 1'b0, '0);
		end
		drain_results();

		// random traffic, mostly small trees; the tail runs without idling
		done = 0;
		while (done < RAND_WORDS) begin
			if (done >= RAND_WORDS - CALM_TAIL)
				calm = 1'b1;
			pick = $urandom_range(0, 99);
			data = pick_value();
			if (pick < 4) begin
				case ($urandom_range(0, 2))
				0: code = OP_RSVD_5;
				1: code = OP_RSVD_6;
				default: code = OP_RSVD_7;
				endcase
			end else if (pick < 44 && tree_count <= 20) begin
				code = OP_INSERT;
			end else if (pick < 74) begin
				code = OP_DELETE;
				if (tree_count > 0 && $urandom_range(0, 3) != 0)
					data = stored_value();
			end else begin
				code = pick_walk();
			end
			send_word(code, data, 1'b0, '0);
			if (pick >= 4)
				done++;
		end
		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d words in (%0d with spare op codes), %0d result words checked",
			items_sent + spare_sent, spare_sent, words_checked);
		$display("full refusals %0d, empty walks %0d, misses %0d, traversal items %0d",
			seen_status[ST_FULL], seen_status[ST_EMPTY], seen_status[ST_NOT_FOUND],
			seen_status[ST_ITEM]);
		if (mismatch_count == 0 && pending_words.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_walk.sv
rtl/complete_tree_store.sv
bench/tb_complete_tree_store.sv
